// File: src/u2w_pkg.sv
// ----------------------------------------------------------------------------
// u2w_pkg
// Shared types, codes and the code point table of the UTF-8 to Windows-1252
// converter.
// ----------------------------------------------------------------------------
package u2w_pkg;

   localparam int BYTE_W = 8;
   localparam int ERR_W  = 2;
   localparam int KIND_W = 3;
   localparam int CP_W   = 16;

   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_TRUNC = 2'd1;
   localparam logic [ERR_W-1:0] ERR_CONT  = 2'd2;

   localparam logic [KIND_W-1:0] KIND_ONE   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TWO   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_THREE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FOUR  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TRUNC = 3'd4;
   localparam logic [KIND_W-1:0] KIND_CONT  = 3'd5;

   localparam logic [BYTE_W-1:0] BYTE_UNMAPPED = 8'h7F;

   localparam logic [CP_W-1:0] CP_BLOCK80 [32] = '{
      16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
      16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
      16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
      16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
   };

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] b1;
      logic [BYTE_W-1:0] b2;
      logic [BYTE_W-1:0] b3;
   } u2w_job_type;

   typedef struct packed {
      logic        push;
      u2w_job_type job;
   } u2w_push_type;

   // Returns {hit, byte} for a code point of 0x80 or above.
   function automatic logic [BYTE_W:0] u2w_map_cp(input logic [CP_W-1:0] cp);
      logic [BYTE_W:0] res;
      res = '0;
      if (cp >= 16'h00A0 && cp <= 16'h00FF) begin
         res = {1'b1, cp[BYTE_W-1:0]};
      end
      for (int k = 0; k < 32; k++) begin
         if (CP_BLOCK80[k] == cp) begin
            res = {1'b1, 8'h80 | BYTE_W'(k)};
         end
      end
      return res;
   endfunction

endpackage

// File: src/u2w_req_if.sv
// ----------------------------------------------------------------------------
// u2w_req_if
// Input byte channel: valid/ready with one UTF-8 byte and an end mark.
// ----------------------------------------------------------------------------
interface u2w_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       string_end;

   modport source (output valid, output byte_in, output string_end, input ready);
   modport sink   (input valid, input byte_in, input string_end, output ready);
endinterface

// File: src/u2w_rsp_if.sv
// ----------------------------------------------------------------------------
// u2w_rsp_if
// Result channel: valid/ready with one Windows-1252 byte and its status.
// ----------------------------------------------------------------------------
interface u2w_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] error_kind;
   logic       run_last;

   modport source (output valid, output out_byte, output error_kind, output run_last,
                   input ready);
   modport sink   (input valid, input out_byte, input error_kind, input run_last,
                   output ready);
endinterface

// File: src/utf8_to_windows1252_converter_core.sv
// ----------------------------------------------------------------------------
// utf8_to_windows1252_converter_core
// UTF-8 to Windows-1252 transcoder, top level.
// ----------------------------------------------------------------------------
// One UTF-8 byte is accepted per cycle unless the queue is full. A byte that
// completes a sequence, ends a string early or breaks a sequence queues a job.
// With the queue empty and the output free, the first result reaches the result
// register at the edge after the one that accepts that byte. Most jobs give one
// result beat; an unmapped two-byte sequence gives two, and the single result
// register, which emits one beat per cycle while ready is high, sets that cost.
// The two-entry job queue keeps input acceptance going while a result waits.
module utf8_to_windows1252_converter_core (
   input  logic      clock,
   input  logic      reset,
   u2w_req_if.sink   req_ch,
   u2w_rsp_if.source rsp_ch
);
   import u2w_pkg::*;

   u2w_push_type push;
   u2w_job_type  head;
   logic         q_full;
   logic         head_valid;
   logic         pop;

   u2w_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .q_full   (q_full),
      .push_out (push)
   );

   u2w_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_in    (push),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head)
   );

   u2w_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

// File: src/u2w_front.sv
// ----------------------------------------------------------------------------
// u2w_front
// Accepts input bytes, collects sequences and classifies them into jobs.
// ----------------------------------------------------------------------------
module u2w_front (
   input  logic                 clock,
   input  logic                 reset,
   u2w_req_if.sink              req_ch,
   input  logic                 q_full,
   output u2w_pkg::u2w_push_type push_out
);
   import u2w_pkg::*;

   logic [1:0]        len_ff, len_in;
   logic [2:0]        need_ff, need_in;
   logic [BYTE_W-1:0] b1_ff, b1_in, b2_ff, b2_in, b3_ff, b3_in;
   logic              accept;
   logic [2:0]        need_new, len_next;
   logic [BYTE_W-1:0] b;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && !q_full;
   assign b            = req_ch.byte_in;

   always_comb begin
      len_in   = len_ff;
      need_in  = need_ff;
      b1_in    = b1_ff;
      b2_in    = b2_ff;
      b3_in    = b3_ff;
      push_out = '0;
      len_next = {1'b0, len_ff} + 3'd1;
      if (b < 8'h80) begin
         need_new = 3'd1;
      end else if (b < 8'hE0) begin
         need_new = 3'd2;
      end else if (b < 8'hF0) begin
         need_new = 3'd3;
      end else begin
         need_new = 3'd4;
      end
      push_out.job.b1 = b1_ff;
      push_out.job.b2 = (len_ff == 2'd1) ? b : b2_ff;
      push_out.job.b3 = (len_ff == 2'd2) ? b : b3_ff;
      push_out.job.kind = KIND_FOUR;
      if (accept) begin
         if (len_ff == 2'd0) begin
            if (need_new == 3'd1) begin
               push_out.push    = 1'b1;
               push_out.job.kind = KIND_ONE;
               push_out.job.b1   = b;
            end else if (req_ch.string_end) begin
               push_out.push    = 1'b1;
               push_out.job.kind = KIND_TRUNC;
            end else begin
               b1_in   = b;
               need_in = need_new;
               len_in  = 2'd1;
            end
         end else if (!b[7]) begin
            push_out.push    = 1'b1;
            push_out.job.kind = KIND_CONT;
            len_in  = 2'd0;
            need_in = 3'd0;
         end else begin
            if (len_ff == 2'd1) begin
               b2_in = b;
            end
            if (len_ff == 2'd2) begin
               b3_in = b;
            end
            if (len_next >= need_ff) begin
               push_out.push = 1'b1;
               case (need_ff)
                  3'd2:    push_out.job.kind = KIND_TWO;
                  3'd3:    push_out.job.kind = KIND_THREE;
                  default: push_out.job.kind = KIND_FOUR;
               endcase
               len_in  = 2'd0;
               need_in = 3'd0;
            end else if (req_ch.string_end) begin
               push_out.push    = 1'b1;
               push_out.job.kind = KIND_TRUNC;
               len_in  = 2'd0;
               need_in = 3'd0;
            end else begin
               len_in = len_next[1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         need_ff <= '0;
      end else begin
         len_ff  <= len_in;
         need_ff <= need_in;
      end
      b1_ff <= b1_in;
      b2_ff <= b2_in;
      b3_ff <= b3_in;
   end

   a_len_below_need: assert property (@(posedge clock) disable iff (reset)
      len_ff != 2'd0 |-> {1'b0, len_ff} < need_ff)
      else $error("sequence length reached its need without completing");

endmodule

// File: src/u2w_queue.sv
// ----------------------------------------------------------------------------
// u2w_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module u2w_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  u2w_pkg::u2w_push_type push_in,
   input  logic                  pop,
   output logic                  full,
   output logic                  head_valid,
   output u2w_pkg::u2w_job_type  head
);
   import u2w_pkg::*;

   u2w_job_type mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_in.push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push_in.push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_in.push) begin
         mem_ff[wr_ptr_ff] <= push_in.job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_in.push |-> count_ff != 2'd2)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 2'd0)
      else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

endmodule

// File: src/u2w_back.sv
// ----------------------------------------------------------------------------
// u2w_back
// Maps queued jobs to Windows-1252 bytes and drives the result register.
// ----------------------------------------------------------------------------
module u2w_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  u2w_pkg::u2w_job_type head,
   output logic                 pop,
   u2w_rsp_if.source            rsp_ch
);
   import u2w_pkg::*;

   logic              valid_ff;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [ERR_W-1:0]  err_ff, err_in;
   logic              last_ff, last_in;
   logic              phase_ff, phase_in;
   logic              load;
   logic [CP_W-1:0]   cp2, cp3;
   logic [BYTE_W:0]   map2, map3;
   logic              hit2, hit3;

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.out_byte   = byte_ff;
   assign rsp_ch.error_kind = err_ff;
   assign rsp_ch.run_last   = last_ff;

   assign load = head_valid && (!valid_ff || rsp_ch.ready);

   always_comb begin
      cp2  = {5'd0, head.b1[4:0], head.b2[5:0]};
      cp3  = {head.b1[3:0], head.b2[5:0], head.b3[5:0]};
      map2 = u2w_map_cp(cp2);
      map3 = u2w_map_cp(cp3);
      hit2 = head.b1[7:5] == 3'b110 && head.b2[7:6] == 2'b10 && cp2 >= 16'h0080 && map2[BYTE_W];
      hit3 = head.b1[7:4] == 4'hE && head.b2[7:6] == 2'b10 && head.b3[7:6] == 2'b10
             && cp3 >= 16'h0800 && map3[BYTE_W];
      byte_in  = BYTE_UNMAPPED;
      err_in   = ERR_NONE;
      last_in  = 1'b1;
      phase_in = phase_ff;
      case (head.kind)
         KIND_ONE: begin
            byte_in = head.b1;
         end
         KIND_TWO: begin
            if (hit2) begin
               byte_in = map2[BYTE_W-1:0];
            end else begin
               byte_in = phase_ff ? head.b2 : head.b1;
               last_in = phase_ff;
            end
         end
         KIND_THREE: begin
            byte_in = hit3 ? map3[BYTE_W-1:0] : BYTE_UNMAPPED;
         end
         KIND_TRUNC: begin
            byte_in = '0;
            err_in  = ERR_TRUNC;
         end
         KIND_CONT: begin
            byte_in = '0;
            err_in  = ERR_CONT;
         end
         default: begin
            byte_in = BYTE_UNMAPPED;
         end
      endcase
      pop = load && last_in;
      if (load) begin
         phase_in = !last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            valid_ff <= 1'b0;
         end
      end
      if (load) begin
         byte_ff <= byte_in;
         err_ff  <= err_in;
         last_ff <= last_in;
      end
   end

   a_phase_on_raw_pair: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> head_valid && head.kind == KIND_TWO)
      else $error("second raw byte pending without a two-byte job");

   a_first_raw_not_last: assert property (@(posedge clock) disable iff (reset)
      $rose(phase_ff) |-> valid_ff && !last_ff)
      else $error("first raw byte marked as last");

endmodule

// File: tb/sv/tb_utf8_to_windows1252_converter_core.sv
// ----------------------------------------------------------------------------
// tb_utf8_to_windows1252_converter_core
// Self-checking bench for the UTF-8 to Windows-1252 transcoder. Drives UTF-8
// strings (clean text, unmapped and overlong forms, truncated and broken
// sequences, raw noise) under random valid/ready gaps. An in-bench decoder
// predicts every result beat and compares each one in order.
// ----------------------------------------------------------------------------
module tb_utf8_to_windows1252_converter_core;
   import u2w_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int ITEM_GOAL   = 1850;

   typedef struct packed {
      logic [BYTE_W-1:0] wbyte;
      logic [ERR_W-1:0]  err;
      logic              last;
   } cp1252_beat_type;

   class cp1252_scoreboard_type;
      logic [31:0]       seq_bytes;
      logic [2:0]        seq_len;
      logic [2:0]        seq_need;
      cp1252_beat_type   due[$];
      int                fails;
      int                beats;
      int                bytes_in;
      int                truncs;
      int                bad_conts;
      int                raw_pairs;

      function new();
         clear_seq();
         fails     = 0;
         beats     = 0;
         bytes_in  = 0;
         truncs    = 0;
         bad_conts = 0;
         raw_pairs = 0;
      endfunction

      function void clear_seq();
         seq_bytes = '0;
         seq_len   = '0;
         seq_need  = '0;
      endfunction

      function void queue_beat(input logic [7:0] wb, input logic [1:0] err, input logic last);
         cp1252_beat_type b;
         b.wbyte = wb;
         b.err   = err;
         b.last  = last;
         due = {due, b};
      endfunction

      function bit lookup_1252(input logic [15:0] cp, output logic [7:0] wb);
         wb = BYTE_UNMAPPED;
         if (cp >= 16'h00A0 && cp <= 16'h00FF) begin
            wb = cp[7:0];
            return 1'b1;
         end
         for (int k = 0; k < 32; k++) begin
            if (CP_BLOCK80[k] == cp) begin
               wb = 8'h80 + 8'(k);
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_byte(input logic [7:0] b, input logic fin);
         logic [7:0]  b1;
         logic [7:0]  b2;
         logic [7:0]  b3;
         logic [7:0]  wb;
         logic [15:0] cp;
         logic [2:0]  need;
         bytes_in++;
         if (seq_len == 3'd0) begin
            seq_need  = (b < 8'h80) ? 3'd1 : (b < 8'hE0) ? 3'd2 : (b < 8'hF0) ? 3'd3 : 3'd4;
            seq_bytes = {24'd0, b};
            seq_len   = 3'd1;
         end else begin
            if (b < 8'h80) begin
               clear_seq();
               queue_beat(8'h00, ERR_CONT, 1'b1);
               bad_conts++;
               return;
            end
            if (seq_len < 3'd4) begin
               seq_bytes = seq_bytes | ({24'd0, b} << (8 * seq_len));
            end
            seq_len = seq_len + 3'd1;
         end
         if (seq_len < seq_need) begin
            if (fin) begin
               clear_seq();
               queue_beat(8'h00, ERR_TRUNC, 1'b1);
               truncs++;
            end
            return;
         end
         b1   = seq_bytes[7:0];
         b2   = seq_bytes[15:8];
         b3   = seq_bytes[23:16];
         need = seq_need;
         wb   = BYTE_UNMAPPED;
         clear_seq();
         if (need == 3'd1) begin
            wb = b1;
         end else if (need == 3'd2) begin
            if (b1[7:5] == 3'b110 && b2[7:6] == 2'b10) begin
               cp = {5'd0, b1[4:0], b2[5:0]};
               if (cp >= 16'h0080 && lookup_1252(cp, wb)) begin
                  queue_beat(wb, ERR_NONE, 1'b1);
                  return;
               end
            end
            queue_beat(b1, ERR_NONE, 1'b0);
            queue_beat(b2, ERR_NONE, 1'b1);
            raw_pairs++;
            return;
         end else if (need == 3'd3) begin
            if (b1[7:4] == 4'b1110 && b2[7:6] == 2'b10 && b3[7:6] == 2'b10) begin
               cp = {b1[3:0], b2[5:0], b3[5:0]};
               if (!(cp >= 16'h0800 && lookup_1252(cp, wb))) begin
                  wb = BYTE_UNMAPPED;
               end
            end
         end
         queue_beat(wb, ERR_NONE, 1'b1);
      endfunction

      task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
         fails++;
         if (fails <= 30) begin
            $display("mismatch at result beat %0d: %s got %0h want %0h", beats, what, got, want);
         end
      endtask

      task check_beat(input logic [7:0] ob, input logic [1:0] ek, input logic rl);
         cp1252_beat_type want;
         beats++;
         if (due.size() == 0) begin
            report_mismatch("unexpected beat, out_byte", ob, 0);
            return;
         end
         want = due.pop_front();
         if (ob !== want.wbyte) report_mismatch("out_byte", ob, want.wbyte);
         if (ek !== want.err) report_mismatch("error_kind", ek, want.err);
         if (rl !== want.last) report_mismatch("run_last", rl, want.last);
      endtask

      task final_check();
         if (due.size() != 0) report_mismatch("beats still owed", due.size(), 0);
      endtask
   endclass

   logic clock;
   logic reset;
   int   cycles;
   int   items_sent;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   hold_left;
   cp1252_scoreboard_type board;

   u2w_req_if req ();
   u2w_rsp_if rsp ();

   utf8_to_windows1252_converter_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("** utf8_to_windows1252_converter_core: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) board.note_byte(req.byte_in, req.string_end);
         if (rsp.valid && rsp.ready) board.check_beat(rsp.out_byte, rsp.error_kind, rsp.run_last);
      end
   end

   initial begin
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid      <= 1'b1;
      req.byte_in    <= b;
      req.string_end <= fin;
      do @(posedge clock); while (!req.ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (board.due.size() != 0) @(negedge clock);
   endtask

   task automatic set_idling(input int sp, input int rp, input int hold);
      @(posedge clock);
      send_idle_pct = sp;
      recv_idle_pct = rp;
      hold_left     = hold;
      @(negedge clock);
   endtask

   function automatic logic [7:0] cont_byte();
      if ($urandom_range(9) == 0) return 8'($urandom_range(8'hC0, 8'hFF));
      return 8'($urandom_range(8'h80, 8'hBF));
   endfunction

   task automatic send_cp(input logic [15:0] cp, input logic fin);
      if (cp < 16'h0080) begin
         send_byte(cp[7:0], fin);
      end else if (cp < 16'h0800) begin
         send_byte({3'b110, cp[10:6]}, 1'b0);
         send_byte({2'b10, cp[5:0]}, fin);
      end else begin
         send_byte({4'b1110, cp[15:12]}, 1'b0);
         send_byte({2'b10, cp[11:6]}, 1'b0);
         send_byte({2'b10, cp[5:0]}, fin);
      end
   endtask

   task automatic send_string();
      int         n_chars;
      int         pick;
      int         need;
      int         nb;
      logic       fin;
      logic [7:0] lead;
      logic [15:0] cp;
      n_chars = $urandom_range(1, 10);
      for (int i = 0; i < n_chars; i++) begin
         fin  = (i == n_chars - 1);
         pick = $urandom_range(99);
         lead = 8'($urandom_range(8'h80, 8'hFF));
         need = (lead >= 8'hF0) ? 4 : (lead >= 8'hE0) ? 3 : 2;
         if (pick < 28) begin
            send_byte(8'($urandom_range(0, 127)), fin);
         end else if (pick < 50) begin
            cp = $urandom_range(1) ? CP_BLOCK80[$urandom_range(31)]
                                   : 16'($urandom_range(16'h00A0, 16'h00FF));
            send_cp(cp, fin);
         end else if (pick < 58) begin
            send_byte(8'($urandom_range(8'h80, 8'hDF)), 1'b0);
            send_byte(cont_byte(), fin);
         end else if (pick < 66) begin
            send_byte(8'($urandom_range(8'hE0, 8'hEF)), 1'b0);
            send_byte(cont_byte(), 1'b0);
            send_byte(cont_byte(), fin);
         end else if (pick < 72) begin
            send_byte(8'($urandom_range(8'hF0, 8'hFF)), 1'b0);
            send_byte(cont_byte(), 1'b0);
            send_byte(cont_byte(), 1'b0);
            send_byte(cont_byte(), fin);
         end else if (pick < 80) begin
            // cut the sequence short at the string end
            nb = 1 + $urandom_range(0, need - 2);
            for (int j = 0; j < nb; j++) begin
               send_byte((j == 0) ? lead : cont_byte(), j == nb - 1);
            end
            break;
         end else if (pick < 88) begin
            // break the sequence with an ASCII byte
            nb = $urandom_range(0, need - 2);
            send_byte(lead, 1'b0);
            for (int j = 0; j < nb; j++) send_byte(cont_byte(), 1'b0);
            send_byte(8'($urandom_range(0, 127)), fin | ($urandom_range(3) == 0));
         end else begin
            send_byte(8'($urandom), fin | ($urandom_range(3) == 0));
         end
      end
   endtask

   task automatic run_strings(input int goal);
      while (items_sent < goal) send_string();
   endtask

   task automatic run_directed();
      logic [8:0] script[$];
      // bit 8 marks the string end
      script = '{9'h100, 9'h07F, 9'h0C2, 9'h0A0, 9'h0C3, 9'h1BF, 9'h0E2, 9'h082,
                 9'h0AC, 9'h0C2, 9'h081, 9'h0C2, 9'h080, 9'h0F0, 9'h09F, 9'h098,
                 9'h080, 9'h0E0, 9'h082, 9'h0AC, 9'h0C3, 9'h141, 9'h0E2, 9'h182};
      foreach (script[i]) send_byte(script[i][7:0], script[i][8]);
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      cycles         = 0;
      items_sent     = 0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      hold_left      = 0;
      req.valid      = 1'b0;
      req.byte_in    = '0;
      req.string_end = 1'b0;
      board          = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();
      drain();

      // hold the receiver off while bytes keep coming, then pause until empty
      set_idling(15, 72, 150);
      run_strings(items_sent + 80);
      drain();
      run_strings(650);
      drain();

      set_idling(72, 15, 0);
      run_strings(1250);
      drain();

      set_idling(0, 0, 0);
      run_strings(ITEM_GOAL);
      drain();

      repeat (20) @(posedge clock);
      board.final_check();
      $display("covered %0d input bytes and %0d result beats in %0d cycles",
               board.bytes_in, board.beats, cycles);
      $display("incl. %0d raw two-byte pairs, %0d truncations, %0d bad continuations",
               board.raw_pairs, board.truncs, board.bad_conts);
      if (board.fails == 0) begin
         $display("** utf8_to_windows1252_converter_core: PASSED **");
      end else begin
         $display("** utf8_to_windows1252_converter_core: FAILED **");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/u2w_pkg.sv
src/u2w_req_if.sv
src/u2w_rsp_if.sv
src/u2w_front.sv
src/u2w_queue.sv
src/u2w_back.sv
src/utf8_to_windows1252_converter_core.sv
tb/sv/tb_utf8_to_windows1252_converter_core.sv
